// ===== rtl/ipd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// shared types and constants of the 11-byte inertial packet deframer
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned PKT_LEN  = 11;
  localparam logic [3:0]  LAST_IDX = 4'(PKT_LEN - 1);

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_ANG = 8'h53;

  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_GYR = 2'd1;
  localparam logic [1:0] KIND_ANG = 2'd2;

  // one decoded packet waiting for scaling
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] raw_a;
    logic [15:0] raw_b;
    logic [15:0] raw_c;
    logic [15:0] raw_d;
  } cmd_t;

endpackage

// ===== rtl/ipd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_front
// byte framing, packet store, checksum and type check
// ----------------------------------------------------------------------------
module ipd_front #(
  parameter int unsigned MAX_BURST_BYTES = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             burst_start,
  input  logic             q_full,
  output logic             push,
  output ipd_pkg::cmd_t    push_cmd
);

  localparam logic [5:0] MaxBurst = 6'(MAX_BURST_BYTES);

  logic [3:0] byte_in_packet;
  logic [5:0] bytes_in_burst;
  logic [7:0] running_sum;
  logic [7:0] store [10];

  logic [3:0] bip_e;
  logic [5:0] bib_e;
  logic [7:0] sum_e;
  logic       take;
  logic       room;
  logic       closing;
  logic       type_ok;
  logic [1:0] kind;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    bip_e   = burst_start ? 4'd0 : byte_in_packet;
    bib_e   = burst_start ? 6'd0 : bytes_in_burst;
    sum_e   = burst_start ? 8'd0 : running_sum;
    room    = bib_e < MaxBurst;
    closing = bip_e == ipd_pkg::LAST_IDX;
    type_ok = store[1] inside {ipd_pkg::TYPE_ACC, ipd_pkg::TYPE_GYR, ipd_pkg::TYPE_ANG};
    case (store[1])
      ipd_pkg::TYPE_ACC: kind = ipd_pkg::KIND_ACC;
      ipd_pkg::TYPE_GYR: kind = ipd_pkg::KIND_GYR;
      default:           kind = ipd_pkg::KIND_ANG;
    endcase
  end

  assign push = take && room && closing && (store[0] == ipd_pkg::HDR_BYTE)
                && (sum_e == rx_byte) && type_ok;

  assign push_cmd = '{kind:  kind,
                      raw_a: {store[3], store[2]},
                      raw_b: {store[5], store[4]},
                      raw_c: {store[7], store[6]},
                      raw_d: {store[9], store[8]}};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_packet <= 4'd0;
      bytes_in_burst <= 6'd0;
      running_sum    <= 8'd0;
    end else if (take && room) begin
      bytes_in_burst <= bib_e + 6'd1;
      if (closing) begin
        byte_in_packet <= 4'd0;
        running_sum    <= 8'd0;
      end else begin
        byte_in_packet <= bip_e + 4'd1;
        running_sum    <= sum_e + rx_byte;
      end
    end
  end

  // packet bytes 0 to 9
  always_ff @(posedge clk) begin
    if (take && room && !closing) begin
      store[bip_e] <= rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_bip_range: assert property (@(posedge clk) disable iff (rst)
    byte_in_packet <= ipd_pkg::LAST_IDX) else $error("packet position out of range");
  a_bib_range: assert property (@(posedge clk) disable iff (rst)
    bytes_in_burst <= MaxBurst) else $error("burst count past limit");
`endif

endmodule

// ===== rtl/ipd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_queue
// two-entry queue of decoded packets between front and back
// ----------------------------------------------------------------------------
module ipd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ipd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ipd_pkg::cmd_t head_cmd
);

  ipd_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && !head_valid)) else $error("queue over or underflow");
`endif

endmodule

// ===== rtl/ipd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_back
// two-stage scaling of decoded packets to q.8 values
// ----------------------------------------------------------------------------
module ipd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ipd_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         packet_kind,
  output logic signed [23:0] value_a,
  output logic signed [23:0] value_b,
  output logic signed [23:0] value_c,
  output logic signed [23:0] value_d
);

  // ceil(2^27 / 25): exact floor(n / 25) for n below 2^22
  localparam logic [22:0] TempRecip = 23'd5368710;

  localparam logic signed [23:0] MulAcc = 24'sd125;
  localparam logic signed [23:0] MulAng = 24'sd45;

  // stage 1 registers
  logic               s1_valid;
  logic [1:0]         s1_kind;
  logic signed [23:0] s1_a;
  logic signed [23:0] s1_b;
  logic signed [23:0] s1_c;
  logic [16:0]        s1_tq;
  logic               s1_tneg;
  logic [15:0]        s1_rawd;

  logic               s2_load;
  logic               s1_load;
  logic signed [23:0] mul;
  logic [16:0]        t_abs;
  logic [39:0]        t_prod;

  function automatic logic signed [23:0] scale(input logic [15:0] raw,
                                               input logic signed [23:0] m);
    logic signed [23:0] ext;
    ext   = 24'($signed(raw));
    scale = ext * m;
  endfunction

  function automatic logic signed [23:0] shift_kind(input logic [1:0] k,
                                                    input logic signed [23:0] p);
    case (k)
      ipd_pkg::KIND_ACC: shift_kind = p;
      ipd_pkg::KIND_GYR: shift_kind = p >>> 3;
      default:           shift_kind = p >>> 5;
    endcase
  endfunction

  assign s2_load = s1_valid && (!out_valid || out_ready);
  assign s1_load = !s1_valid || s2_load;
  assign pop     = head_valid && s1_load;

  always_comb begin
    mul    = (head_cmd.kind == ipd_pkg::KIND_ANG) ? MulAng : MulAcc;
    t_abs  = head_cmd.raw_d[15] ? 17'(17'd0 - {1'b1, head_cmd.raw_d})
                                : {1'b0, head_cmd.raw_d};
    t_prod = 40'(t_abs) * 40'(TempRecip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= head_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind <= head_cmd.kind;
      s1_a    <= scale(head_cmd.raw_a, mul);
      s1_b    <= scale(head_cmd.raw_b, mul);
      s1_c    <= scale(head_cmd.raw_c, mul);
      s1_tq   <= t_prod[37:21];
      s1_tneg <= head_cmd.raw_d[15];
      s1_rawd <= head_cmd.raw_d;
    end
    if (s2_load) begin
      packet_kind <= s1_kind;
      value_a     <= shift_kind(s1_kind, s1_a);
      value_b     <= shift_kind(s1_kind, s1_b);
      value_c     <= shift_kind(s1_kind, s1_c);
      case (s1_kind)
        ipd_pkg::KIND_ACC: value_d <= s1_tneg ? 24'sd0 - 24'($signed({1'b0, s1_tq}))
                                              : 24'($signed({1'b0, s1_tq}));
        ipd_pkg::KIND_GYR: value_d <= 24'sd0;
        default:           value_d <= 24'($signed(s1_rawd));
      endcase
    end
  end

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_kind != 2'd3) else $error("illegal packet kind");
  a_gyr_zero_d: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_kind == ipd_pkg::KIND_GYR |-> value_d == 24'sd0)
    else $error("angular rate packet with non-zero fourth value");
`endif

endmodule

// ===== rtl/imu_packet_deframer_11byte_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_11byte_unit
// deframer for 11-byte inertial sensor uart packets with q.8 scaling
// ----------------------------------------------------------------------------
// input channel: one uart byte per beat (rx_byte, burst_start) on in_valid /
//   in_ready; burst_start restarts framing at offset 0 of an 11-byte packet
// output channel: one beat per good packet (packet_kind, value_a..value_d)
//   on out_valid / out_ready; bad header, bad sum or unknown type gives none
// throughput: one byte per cycle unless the queue is full, set by the front
//   end framing and sum update; the back end takes one packet per cycle unless stalled
// path: the beat that carries the checksum byte pushes the packet into
//   the queue, then the product stage, then the output register
// stalls: the output register, the product stage and the two-entry queue
//   hold finished packets; in_ready drops only when the queue is full
// reset: framing, burst count, sum and all valid flags clear; framing then
//   behaves as if a burst had just begun
// ----------------------------------------------------------------------------
module imu_packet_deframer_11byte_unit #(
  parameter int unsigned MAX_BURST_BYTES = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               burst_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         packet_kind,
  output logic signed [23:0] value_a,
  output logic signed [23:0] value_b,
  output logic signed [23:0] value_c,
  output logic signed [23:0] value_d
);

  // decoded packet handed from front to queue
  ipd_pkg::cmd_t push_cmd;
  logic          push;
  logic          q_full;

  // queue head seen by the back end
  ipd_pkg::cmd_t head_cmd;
  logic          head_valid;
  logic          pop;

  // framing, checksum and type decode
  ipd_front #(
    .MAX_BURST_BYTES (MAX_BURST_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .burst_start (burst_start),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // decouples framing from a stalled receiver
  ipd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // constant multiplies, shifts and temperature division
  ipd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packet_kind (packet_kind),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c),
    .value_d     (value_d)
  );

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> in_valid && in_ready) else $error("packet pushed without an accepted byte");
`endif

endmodule
